[rtl/lzwd_pkg.sv]
// Shared constants and control/status types for the LZW variable-width decoder.
package lzwd_pkg;

  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int STACK_DEPTH_DEF   = 4096;
  localparam int DICT_ENTRIES_DEF  = 4096;

  localparam int CLEAR_CODE = 'h100;
  localparam int END_CODE   = 'h101;
  localparam int FIRST_FREE = 'h102;
  localparam int MIN_WIDTH  = 9;
  localparam int BYTE_MAX   = 'hff;

  localparam int OUT_TDATA_W = 16;

  typedef struct packed {
    logic accept;
    logic pop_cap;
    logic check;
    logic walk;
    logic walk_cap;
    logic finish;
  } lzwd_cmd_t;

  typedef struct packed {
    logic pop_ok;
    logic needs_walk;
    logic walk_read;
    logic walk_end;
  } lzwd_stat_t;

endpackage

[rtl/lzw_variable_width_decoder_core.sv]
// Top level of the LZW variable-width decoder.
// Sequence: a transaction is accepted, a pull that finds data adds a stack RAM read, then the
// decode check runs; a decode walks the prefix chain, one dictionary RAM read per link, then finishes.
// Throughput: one transaction in flight; next input taken the cycle after the result is taken.
// Reset: synchronous active-low; clears control and dictionary state, RAM contents stay as is.
module lzw_variable_width_decoder_core
  import lzwd_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int DICT_ENTRIES  = DICT_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // packed_byte
  input  logic                   in_tuser,   // kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // byte_taken, out_valid, out_byte[7:0],
                                             // finished, bad_code, zero pad
);

  lzwd_cmd_t  cmd;
  lzwd_stat_t stat;

  lzwd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lzwd_dp #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .STACK_DEPTH   (STACK_DEPTH),
    .DICT_ENTRIES  (DICT_ENTRIES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_kind (in_tuser),
    .in_byte (in_tdata),
    .cmd     (cmd),
    .stat    (stat),
    .result  (out_tdata)
  );

endmodule

[rtl/lzwd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lzwd_ctrl.sv]
// Sequencing state machine for the LZW decoder.
module lzwd_ctrl
  import lzwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  lzwd_stat_t stat,
  output lzwd_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_POPW   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_WALK   = 7'b0001000,
    S_WALKW  = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = stat.pop_ok ? S_POPW : S_CHECK;
        end
      end
      S_POPW:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = stat.needs_walk ? S_WALK : S_RESP;
      S_WALK: begin
        if (stat.walk_read) begin
          state_nxt = S_WALKW;
        end else if (stat.walk_end) begin
          state_nxt = S_FINISH;
        end
      end
      S_WALKW:  state_nxt = S_WALK;
      S_FINISH: state_nxt = S_RESP;
      S_RESP: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = (state_r == S_RESP);
  assign cmd.accept   = (state_r == S_IDLE) && in_tvalid;
  assign cmd.pop_cap  = (state_r == S_POPW);
  assign cmd.check    = (state_r == S_CHECK);
  assign cmd.walk     = (state_r == S_WALK);
  assign cmd.walk_cap = (state_r == S_WALKW);
  assign cmd.finish   = (state_r == S_FINISH);

endmodule

[rtl/lzwd_dp.sv]
// Datapath: bit buffer, dictionary, output stack and decode registers.
module lzwd_dp
  import lzwd_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int DICT_ENTRIES  = DICT_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_kind,
  input  logic [7:0]             in_byte,
  input  lzwd_cmd_t              cmd,
  output lzwd_stat_t             stat,
  output logic [OUT_TDATA_W-1:0] result
);

  localparam int CW  = MAX_CODE_BITS;
  localparam int CWW = $clog2(CW + 1);
  localparam int BW  = CW + 7;
  localparam int HW  = $clog2(CW + 8);
  localparam int NFW = $clog2(DICT_ENTRIES + 1);
  localparam int DAW = $clog2(DICT_ENTRIES);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);

  logic [BW-1:0]  buf_r;
  logic [HW-1:0]  held_r;
  logic [CWW-1:0] cw_r;
  logic [NFW-1:0] nf_r;
  logic [CW-1:0]  prev_r;
  logic           expect_r;
  logic [SCW-1:0] count_r;
  logic           base_r;
  logic           done_r;
  logic           err_r;
  logic [CW-1:0]  cur_r;
  logic [CW-1:0]  code_r;
  logic           kwk_r;
  logic [7:0]     leaf_r;
  logic           taken_r;
  logic           valid_r;
  logic [7:0]     obyte_r;

  logic [CW-1:0]  mask;
  logic [CW-1:0]  code_c;
  logic           can_decode;
  logic           full;
  logic           cur_big;
  logic           cur_in_dict;
  logic [SCW-1:0] st_idx;
  logic [SCW:0]   st_sum;
  logic [SCW:0]   st_phys;
  logic           st_we;
  logic [SAW-1:0] st_waddr;
  logic [7:0]     st_wdata;
  logic [7:0]     st_rdata;
  logic           push_now;
  logic           dict_we;
  logic [CW+7:0]  dict_rdata;
  logic [NFW-1:0] nf_inc;
  logic           add_ok;

  assign mask        = {CW{1'b1}} >> (CWW'(CW) - cw_r);
  assign code_c      = buf_r[CW-1:0] & mask;
  assign can_decode  = !done_r && (count_r == '0) && (held_r >= HW'(cw_r));
  assign full        = (count_r >= SCW'(STACK_DEPTH));
  assign cur_big     = (32'(cur_r) > 32'(BYTE_MAX));
  assign cur_in_dict = (32'(cur_r) < 32'(DICT_ENTRIES));

  assign stat.pop_ok     = in_kind && (count_r != '0);
  assign stat.needs_walk = can_decode && !expect_r && (32'(code_c) != 32'(CLEAR_CODE)) &&
                           (32'(code_c) != 32'(END_CODE));
  assign stat.walk_read  = cur_big && !full && cur_in_dict;
  assign stat.walk_end   = !cur_big || full;

  assign st_idx  = cmd.accept ? (count_r - 1'b1) : count_r;
  assign st_sum  = {1'b0, st_idx} + (SCW + 1)'(base_r);
  assign st_phys = (st_sum >= (SCW + 1)'(STACK_DEPTH)) ? st_sum - (SCW + 1)'(STACK_DEPTH)
                                                       : st_sum;

  assign nf_inc = nf_r + 1'b1;
  assign add_ok = (32'(nf_r) < 32'(DICT_ENTRIES));

  always_comb begin
    push_now = 1'b0;
    st_wdata = 8'h00;
    st_waddr = st_phys[SAW-1:0];
    dict_we  = 1'b0;
    if (cmd.check && can_decode && expect_r) begin
      push_now = 1'b1;
      st_wdata = code_c[7:0];
    end
    if (cmd.walk) begin
      if (cur_big) begin
        if (!full && !cur_in_dict) begin
          push_now = 1'b1;
        end
      end else if (!full) begin
        push_now = 1'b1;
        st_wdata = cur_r[7:0];
      end
    end
    if (cmd.walk_cap) begin
      push_now = 1'b1;
      st_wdata = dict_rdata[7:0];
    end
    if (cmd.finish) begin
      if (kwk_r) begin
        if (!full) begin
          push_now = 1'b1;
          st_wdata = leaf_r;
          st_waddr = '0;
        end
        dict_we = (code_r == CW'(nf_r)) && (32'(code_r) == 32'(nf_r)) && add_ok;
      end else begin
        dict_we = add_ok;
      end
    end
    st_we = push_now;
  end

  lzwd_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_phys[SAW-1:0]),
    .rdata (st_rdata)
  );

  lzwd_ram #(.WIDTH(CW + 8), .DEPTH(DICT_ENTRIES)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (nf_r[DAW-1:0]),
    .wdata ({prev_r, leaf_r}),
    .raddr (cur_r[DAW-1:0]),
    .rdata (dict_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r    <= '0;
      held_r   <= '0;
      cw_r     <= CWW'(MIN_WIDTH);
      nf_r     <= NFW'(FIRST_FREE);
      prev_r   <= '0;
      expect_r <= 1'b0;
      count_r  <= '0;
      base_r   <= 1'b0;
      done_r   <= 1'b0;
      err_r    <= 1'b0;
      taken_r  <= 1'b0;
      valid_r  <= 1'b0;
      obyte_r  <= 8'h00;
    end else begin
      if (push_now) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.accept) begin
        taken_r <= 1'b0;
        valid_r <= 1'b0;
        obyte_r <= 8'h00;
        if (!in_kind) begin
          if (!done_r && (held_r < HW'(cw_r))) begin
            buf_r   <= buf_r | (BW'(in_byte) << held_r);
            held_r  <= held_r + HW'(8);
            taken_r <= 1'b1;
          end
        end else if (count_r != '0) begin
          count_r <= count_r - 1'b1;
          valid_r <= 1'b1;
        end
      end
      if (cmd.pop_cap) begin
        obyte_r <= st_rdata;
      end
      if (cmd.check && can_decode) begin
        buf_r  <= buf_r >> cw_r;
        held_r <= held_r - HW'(cw_r);
        code_r <= code_c;
        if (expect_r) begin
          expect_r <= 1'b0;
          prev_r   <= code_c;
        end else if (32'(code_c) == 32'(CLEAR_CODE)) begin
          cw_r     <= CWW'(MIN_WIDTH);
          nf_r     <= NFW'(FIRST_FREE);
          expect_r <= 1'b1;
          prev_r   <= code_c;
        end else if (32'(code_c) == 32'(END_CODE)) begin
          done_r <= 1'b1;
        end else if (32'(code_c) < 32'(nf_r)) begin
          cur_r  <= code_c;
          kwk_r  <= 1'b0;
          base_r <= 1'b0;
        end else begin
          cur_r  <= prev_r;
          kwk_r  <= 1'b1;
          base_r <= 1'b1;
        end
      end
      if (cmd.walk) begin
        if (cur_big) begin
          if (full) begin
            leaf_r <= cur_r[7:0];
          end else if (!cur_in_dict) begin
            cur_r <= '0;
          end
        end else begin
          leaf_r <= cur_r[7:0];
        end
      end
      if (cmd.walk_cap) begin
        cur_r <= dict_rdata[CW+7:8];
      end
      if (cmd.finish) begin
        if (kwk_r && !full) begin
          base_r <= 1'b0;
        end
        if (kwk_r && (32'(code_r) != 32'(nf_r))) begin
          err_r  <= 1'b1;
          done_r <= 1'b1;
        end else begin
          prev_r <= code_r;
          if (add_ok) begin
            nf_r <= nf_inc;
            if (((32'(nf_inc) >> cw_r) != 32'd0) && (cw_r < CWW'(CW))) begin
              cw_r <= cw_r + 1'b1;
            end
          end
        end
      end
    end
  end

  assign result = {4'b0000, err_r, done_r, obyte_r, valid_r, taken_r};

endmodule

[rtl/lzwd_checker.sv]
// Port-level assertions for the LZW decoder, bound to the top level.
module lzwd_checker
  import lzwd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction accepted while busy");

  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> !out_tvalid)
    else $error("result repeated");

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[11] || out_tdata[10]))
    else $error("bad_code without finished");

endmodule

bind lzw_variable_width_decoder_core lzwd_checker u_lzwd_checker (.*);

[test/tb_top.sv]
// Testbench for the LZW variable-width decoder: generated code streams checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import lzwd_pkg::*;

  localparam bit KIND_OFFER = 1'b0;
  localparam bit KIND_PULL  = 1'b1;
  localparam int DICT_DEPTH = DICT_ENTRIES_DEF;
  localparam int STK_SIZE   = STACK_DEPTH_DEF;
  localparam int MAX_WIDTH  = MAX_CODE_BITS_DEF;
  localparam int ITEM_GOAL  = 550;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    bit       taken;
    bit       valid;
    bit [7:0] data;
    bit       fin;
    bit       bad;
  } lzw_result_t;

  class lzw_scoreboard;
    bit [31:0]   bitbuf;
    int unsigned held;
    int unsigned width;
    bit [12:0]   nf;
    bit [11:0]   prev;
    bit          lit_next;
    bit [7:0]    root_mem[DICT_DEPTH];
    bit [11:0]   pre_mem[DICT_DEPTH];
    bit [7:0]    stk[STK_SIZE];
    bit [12:0]   stk_cnt;
    bit          done;
    bit          err;
    lzw_result_t pending[$];
    int          fails;
    int          checked;
    int          popped;
    int          decoded;

    function new();
      bitbuf = 0; held = 0; width = MIN_WIDTH; nf = 13'(FIRST_FREE); prev = 0;
      lit_next = 0; stk_cnt = 0; done = 0; err = 0;
      fails = 0; checked = 0; popped = 0; decoded = 0;
    endfunction

    function void push_byte(bit [7:0] b);
      if (stk_cnt < STK_SIZE) begin
        stk[stk_cnt] = b;
        stk_cnt++;
      end
    endfunction

    // walk prefix chain onto the stack, return the leaf byte
    function bit [7:0] walk_chain(int unsigned code);
      int unsigned cur;
      bit [7:0] r;
      int unsigned p;
      cur = code;
      while (cur > BYTE_MAX) begin
        if (stk_cnt >= STK_SIZE) return cur[7:0];
        r = 0;
        p = 0;
        if (cur < DICT_DEPTH) begin
          r = root_mem[cur];
          p = pre_mem[cur];
        end
        push_byte(r);
        cur = p;
      end
      push_byte(cur[7:0]);
      return cur[7:0];
    endfunction

    function void add_entry(bit [7:0] root);
      if (nf >= DICT_DEPTH) return;
      root_mem[nf] = root;
      pre_mem[nf] = prev;
      nf++;
      if (nf >= (1 << width) && width < MAX_WIDTH) width++;
    endfunction

    function void decode(bit [11:0] c);
      bit [7:0] first;
      decoded++;
      if (lit_next) begin
        push_byte(c[7:0]);
        lit_next = 0;
        prev = c;
        return;
      end
      if (c == CLEAR_CODE) begin
        width = MIN_WIDTH;
        nf = 13'(FIRST_FREE);
        lit_next = 1;
        prev = c;
        return;
      end
      if (c == END_CODE) begin
        done = 1;
        return;
      end
      if (c < nf) begin
        first = walk_chain(c);
        add_entry(first);
      end else begin
        first = walk_chain(prev);
        if (stk_cnt < STK_SIZE) begin
          for (int i = stk_cnt; i > 0; i--) stk[i] = stk[i-1];
          stk[0] = first;
          stk_cnt++;
        end
        if (c != nf) begin
          err = 1;
          done = 1;
          return;
        end
        add_entry(first);
      end
      prev = c;
    endfunction

    function void note_input(bit kind, bit [7:0] data);
      lzw_result_t r;
      bit [11:0] c;
      r = '{default: 0};
      if (kind == KIND_OFFER) begin
        if (!done && held < width) begin
          bitbuf |= 32'(data) << held;
          held += 8;
          r.taken = 1;
        end
      end else if (stk_cnt > 0) begin
        stk_cnt--;
        r.data = stk[stk_cnt];
        r.valid = 1;
        popped++;
      end
      if (!done && stk_cnt == 0 && held >= width) begin
        c = 12'(bitbuf & ((32'd1 << width) - 1));
        bitbuf >>= width;
        held -= width;
        decode(c);
      end
      r.fin = done;
      r.bad = err;
      pending.push_back(r);
    endfunction

    function void check_result(bit [OUT_TDATA_W-1:0] d);
      lzw_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        fails++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[0] !== e.taken) begin
        $display("%0t: byte_taken exp %0d got %0d", $time, e.taken, d[0]); fails++;
      end
      if (d[1] !== e.valid) begin
        $display("%0t: out_valid exp %0d got %0d", $time, e.valid, d[1]); fails++;
      end
      if (d[9:2] !== e.data) begin
        $display("%0t: out_byte exp %h got %h", $time, e.data, d[9:2]); fails++;
      end
      if (d[10] !== e.fin) begin
        $display("%0t: finished exp %0d got %0d", $time, e.fin, d[10]); fails++;
      end
      if (d[11] !== e.bad) begin
        $display("%0t: bad_code exp %0d got %0d", $time, e.bad, d[11]); fails++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  lzw_scoreboard sb;
  int  cycles = 0;
  int  items;
  bit  in_burst;
  bit  out_burst;

  // stream encoder state
  bit [7:0]    byte_q[$];
  bit [63:0]   enc_acc;
  int unsigned enc_bits;
  int unsigned enc_width;
  int unsigned enc_nf;
  bit          enc_lit;
  bit          stream_ended;
  int          code_idx;

  lzw_variable_width_decoder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lzw_variable_width_decoder_core test failed");
      $finish;
    end
  end

  task automatic emit_code(int unsigned c);
    enc_acc |= 64'(c) << enc_bits;
    enc_bits += enc_width;
    while (enc_bits >= 8) begin
      byte_q.push_back(enc_acc[7:0]);
      enc_acc >>= 8;
      enc_bits -= 8;
    end
    if (enc_lit) begin
      enc_lit = 0;
    end else if (c == CLEAR_CODE) begin
      enc_width = MIN_WIDTH;
      enc_nf = FIRST_FREE;
      enc_lit = 1;
    end else if (c != END_CODE && c <= enc_nf && enc_nf < DICT_DEPTH) begin
      enc_nf++;
      if (enc_nf >= (1 << enc_width) && enc_width < MAX_WIDTH) enc_width++;
    end
  endtask

  task automatic gen_code();
    int unsigned r;
    case (code_idx)
      0, 6: emit_code(CLEAR_CODE);
      1:    emit_code(0);
      2, 7: emit_code(BYTE_MAX);
      3, 8: emit_code(enc_nf);      // code not yet in dictionary
      4:    emit_code(enc_nf - 1);
      5:    emit_code(FIRST_FREE);
      default: begin
        r = $urandom_range(0, 99);
        if (enc_lit || r >= 45) emit_code($urandom_range(0, BYTE_MAX));
        else if (r < 3) emit_code(CLEAR_CODE);
        else emit_code($urandom_range(FIRST_FREE, enc_nf));
      end
    endcase
    code_idx++;
  endtask

  task automatic end_stream();
    if (enc_lit) emit_code($urandom_range(0, BYTE_MAX));
    if ($urandom_range(0, 1) && enc_nf + 1 < (1 << enc_width))
      emit_code($urandom_range(enc_nf + 1, (1 << enc_width) - 1));
    else
      emit_code(END_CODE);
    if (enc_bits > 0) byte_q.push_back(enc_acc[7:0]);
    byte_q.push_back(8'($urandom_range(0, 255)));
    byte_q.push_back(8'($urandom_range(0, 255)));
    stream_ended = 1;
  endtask

  task automatic send(bit kind, bit [7:0] data);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_input(kind, data);
    items++;
    if (items % 60 == 0) in_burst = ($urandom_range(0, 3) == 0);
  endtask

  task automatic next_item();
    bit [7:0] b;
    if (sb.stk_cnt > 0 && $urandom_range(0, 9) != 0) begin
      send(KIND_PULL, 8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 19) == 0 || byte_q.size() == 0) begin
      send(KIND_PULL, 8'($urandom_range(0, 255)));
    end else begin
      b = byte_q[0];
      if (sb.done || (sb.held < sb.width)) void'(byte_q.pop_front());
      send(KIND_OFFER, b);
    end
  endtask

  initial begin
    sb = new();
    items = 0; in_burst = 0;
    enc_acc = 0; enc_bits = 0; enc_width = MIN_WIDTH; enc_nf = FIRST_FREE;
    enc_lit = 0; stream_ended = 0; code_idx = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty pull, then clear, literals, undefined-next code, known code
    send(KIND_PULL, 8'h00);
    while (code_idx < 10 || byte_q.size() > 0 || sb.stk_cnt > 0) begin
      if (byte_q.size() == 0 && sb.stk_cnt == 0 && code_idx < 10) gen_code();
      else if (byte_q.size() == 0 && code_idx < 10) gen_code();
      next_item();
    end
    in_tvalid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    while (!(stream_ended && byte_q.size() == 0 && sb.stk_cnt == 0)) begin
      if (byte_q.size() == 0 && !stream_ended) begin
        if (items >= ITEM_GOAL) end_stream();
        else gen_code();
      end
      next_item();
    end
    in_tvalid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d transactions, decoded %0d codes, popped %0d bytes, checked %0d results.",
             items, sb.decoded, sb.popped, sb.checked);
    $display("Final width %0d, next entry %h, stream ended with %s.",
             sb.width, sb.nf, sb.err ? "a bad code" : "the end code");
    if (sb.fails == 0 && sb.pending.size() == 0)
      $display("lzw_variable_width_decoder_core test passed");
    else
      $display("lzw_variable_width_decoder_core test failed");
    $finish;
  end

  initial begin
    int gap;
    out_tready = 1'b0;
    out_burst = 0;
    @(posedge rst_n);
    forever begin
      gap = out_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
      if (sb.checked % 50 == 0) out_burst = ($urandom_range(0, 3) == 0);
    end
  end

endmodule
